@@ rtl/ipp_pkg.sv @@
// ----------------------------------------------------------------------------
// Intercept point predictor package
// Widths, pipeline depths and shared types of the intercept point predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package ipp_pkg;

   localparam int AXES    = 3;
   localparam int POS_W   = 32;
   localparam int VEL_W   = POS_W + 1;
   localparam int SPD_W   = 31;
   localparam int MUL_W   = 2 * VEL_W;
   localparam int SS_W    = 2 * SPD_W;
   localparam int COEF_W  = 68;
   localparam int HALF_W  = COEF_W / 2;
   localparam int PP_W    = 2 * HALF_W;
   localparam int D_W     = 2 * COEF_W;
   localparam int E_W     = D_W / 2;
   localparam int REM_W   = E_W + 4;
   localparam int NUM_W   = 70;
   localparam int NHALF_W = NUM_W / 2;
   localparam int AVEL_W  = VEL_W;
   localparam int NPP_W   = AVEL_W + NHALF_W;
   localparam int PROD_W  = NPP_W + NHALF_W;
   localparam int Q_W     = 34;
   localparam int DREM_W  = COEF_W;
   localparam int AIM_W   = Q_W + 2;
   localparam int SQRT_N  = E_W;
   localparam int DIV_N   = Q_W;
   localparam int FRONT_N = 6;
   localparam int AXIS_N  = 4 + DIV_N;
   localparam int PIPE_N  = FRONT_N + SQRT_N + 1 + AXIS_N;

   typedef logic signed [POS_W-1:0]  pos_type;
   typedef logic signed [VEL_W-1:0]  vel_type;
   typedef logic signed [MUL_W-1:0]  mul_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [NUM_W-1:0]  num_type;

   typedef enum logic [1:0] {
      CASE_DEGEN  = 2'd0,
      CASE_LINEAR = 2'd1,
      CASE_QUAD   = 2'd2,
      CASE_NOROOT = 2'd3
   } case_type;

   typedef struct packed {
      pos_type [AXES-1:0] cur;
      vel_type [AXES-1:0] vel;
      num_type            num_pre;
      coef_type           den;
      logic               a_neg;
      case_type           kase;
   } side_type;

endpackage

`default_nettype wire

@@ rtl/ipp_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the integer square root: takes two radicand bits,
// produces one root bit and passes the partial result to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ipp_sqrt_cell (
   input  logic                      clock,
   input  logic                      en,
   input  logic [ipp_pkg::D_W-1:0]   prev_rad,
   input  logic [ipp_pkg::REM_W-1:0] prev_rem,
   input  logic [ipp_pkg::E_W-1:0]   prev_root,
   output logic [ipp_pkg::D_W-1:0]   rad,
   output logic [ipp_pkg::REM_W-1:0] rem,
   output logic [ipp_pkg::E_W-1:0]   root
);

   logic [ipp_pkg::D_W-1:0]   rad_ff, rad_in;
   logic [ipp_pkg::REM_W-1:0] rem_ff, rem_in, rem_sh, trial;
   logic [ipp_pkg::E_W-1:0]   root_ff, root_in;
   logic                      ge;

   always_comb begin
      rem_sh  = {prev_rem[ipp_pkg::REM_W-3:0], prev_rad[ipp_pkg::D_W-1 -: 2]};
      trial   = {{(ipp_pkg::REM_W-ipp_pkg::E_W-2){1'b0}}, prev_root, 2'b01};
      ge      = (rem_sh >= trial);
      rem_in  = ge ? (rem_sh - trial) : rem_sh;
      root_in = {prev_root[ipp_pkg::E_W-2:0], ge};
      rad_in  = {prev_rad[ipp_pkg::D_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rad  = rad_ff;
   assign rem  = rem_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

@@ rtl/ipp_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step of the unsigned division: shifts in one dividend bit,
// produces one quotient bit and passes the remainder to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ipp_div_cell (
   input  logic                       clock,
   input  logic                       en,
   input  logic [ipp_pkg::DREM_W-1:0] prev_rem,
   input  logic [ipp_pkg::Q_W-1:0]    prev_dvd,
   input  logic [ipp_pkg::Q_W-1:0]    prev_quo,
   input  logic [ipp_pkg::DREM_W-1:0] prev_den,
   output logic [ipp_pkg::DREM_W-1:0] rem,
   output logic [ipp_pkg::Q_W-1:0]    dvd,
   output logic [ipp_pkg::Q_W-1:0]    quo,
   output logic [ipp_pkg::DREM_W-1:0] den
);

   logic [ipp_pkg::DREM_W-1:0] rem_ff, rem_in, den_ff;
   logic [ipp_pkg::Q_W-1:0]    dvd_ff, dvd_in, quo_ff, quo_in;
   logic [ipp_pkg::DREM_W:0]   rem_sh, den_x, diff;
   logic                       ge;

   always_comb begin
      rem_sh = {prev_rem, prev_dvd[ipp_pkg::Q_W-1]};
      den_x  = {1'b0, prev_den};
      diff   = rem_sh - den_x;
      ge     = (rem_sh >= den_x);
      rem_in = ge ? diff[ipp_pkg::DREM_W-1:0] : rem_sh[ipp_pkg::DREM_W-1:0];
      quo_in = {prev_quo[ipp_pkg::Q_W-2:0], ge};
      dvd_in = {prev_dvd[ipp_pkg::Q_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
         quo_ff <= quo_in;
         den_ff <= prev_den;
      end
   end

   assign rem = rem_ff;
   assign dvd = dvd_ff;
   assign quo = quo_ff;
   assign den = den_ff;

endmodule

`default_nettype wire

@@ rtl/ipp_front.sv @@
// ----------------------------------------------------------------------------
// Coefficient front end
// Forms velocity and offset, the quadratic coefficients and the discriminant
// over six pipeline stages, with wide products split into halves.
// ----------------------------------------------------------------------------
`default_nettype none

module ipp_front (
   input  logic                                    clock,
   input  logic                                    en,
   input  ipp_pkg::pos_type [ipp_pkg::AXES-1:0]    target,
   input  ipp_pkg::pos_type [ipp_pkg::AXES-1:0]    prev,
   input  ipp_pkg::pos_type [ipp_pkg::AXES-1:0]    shooter,
   input  logic [ipp_pkg::SPD_W-1:0]               speed,
   output logic [ipp_pkg::D_W-1:0]                 disc,
   output ipp_pkg::side_type                       side
);

   localparam int H = ipp_pkg::HALF_W;

   ipp_pkg::pos_type [ipp_pkg::AXES-1:0] cur_ff [ipp_pkg::FRONT_N];
   ipp_pkg::vel_type [ipp_pkg::AXES-1:0] vel_ff [ipp_pkg::FRONT_N];
   ipp_pkg::vel_type [ipp_pkg::AXES-1:0] rel0_ff;

   ipp_pkg::mul_type [ipp_pkg::AXES-1:0] vv1_ff, rv1_ff, rr1_ff;
   logic [ipp_pkg::SS_W-1:0]             ss1_ff;

   ipp_pkg::coef_type a2_ff, b2_ff, c2_ff, a2_in, b2_in, c2_in, rv_sum;

   logic [ipp_pkg::COEF_W-1:0] aa, ab, ac_c;
   logic [ipp_pkg::PP_W-1:0]   bll3_ff, blh3_ff, bhh3_ff;
   logic [ipp_pkg::PP_W-1:0]   all3_ff, alh3_ff, ahl3_ff, ahh3_ff;
   ipp_pkg::coef_type          a3_ff, b3_ff, c3_ff, a4_ff, b4_ff, c4_ff;
   logic                       a_neg3_ff, a_neg4_ff, a_neg5_ff;

   logic [ipp_pkg::D_W-1:0] bsq4_ff, ac4_ff, bsq4_in, ac4_in, d5_ff, d5_in;
   logic                    a_zero5_ff, b_zero5_ff, d_pos;
   ipp_pkg::num_type        num5_ff, num5_in;
   ipp_pkg::coef_type       den5_ff, den5_in;

   always_comb begin
      rv_sum = ipp_pkg::coef_type'(rv1_ff[0]) + ipp_pkg::coef_type'(rv1_ff[1])
             + ipp_pkg::coef_type'(rv1_ff[2]);
      a2_in  = ipp_pkg::coef_type'(vv1_ff[0]) + ipp_pkg::coef_type'(vv1_ff[1])
             + ipp_pkg::coef_type'(vv1_ff[2]) - ipp_pkg::coef_type'(ss1_ff);
      b2_in  = rv_sum + rv_sum;
      c2_in  = ipp_pkg::coef_type'(rr1_ff[0]) + ipp_pkg::coef_type'(rr1_ff[1])
             + ipp_pkg::coef_type'(rr1_ff[2]);

      aa   = a2_ff[ipp_pkg::COEF_W-1] ? ipp_pkg::COEF_W'(-a2_ff) : ipp_pkg::COEF_W'(a2_ff);
      ab   = b2_ff[ipp_pkg::COEF_W-1] ? ipp_pkg::COEF_W'(-b2_ff) : ipp_pkg::COEF_W'(b2_ff);
      ac_c = ipp_pkg::COEF_W'(c2_ff);

      bsq4_in = {bhh3_ff, bll3_ff} + (ipp_pkg::D_W'(blh3_ff) << (H + 1));
      ac4_in  = {ahh3_ff, all3_ff} + (ipp_pkg::D_W'(alh3_ff) << H)
              + (ipp_pkg::D_W'(ahl3_ff) << H);

      d5_in   = a_neg4_ff ? (bsq4_ff + (ac4_ff << 2)) : (bsq4_ff - (ac4_ff << 2));
      num5_in = (a4_ff == '0) ? -ipp_pkg::num_type'(c4_ff) : -ipp_pkg::num_type'(b4_ff);
      den5_in = (a4_ff == '0) ? b4_ff : (a4_ff + a4_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < ipp_pkg::AXES; i++) begin
            cur_ff[0][i] <= target[i];
            vel_ff[0][i] <= ipp_pkg::vel_type'(target[i]) - ipp_pkg::vel_type'(prev[i]);
            rel0_ff[i]   <= ipp_pkg::vel_type'(target[i]) - ipp_pkg::vel_type'(shooter[i]);
            vv1_ff[i]    <= vel_ff[0][i] * vel_ff[0][i];
            rv1_ff[i]    <= rel0_ff[i] * vel_ff[0][i];
            rr1_ff[i]    <= rel0_ff[i] * rel0_ff[i];
         end
         for (int k = 1; k < ipp_pkg::FRONT_N; k++) begin
            cur_ff[k] <= cur_ff[k-1];
            vel_ff[k] <= vel_ff[k-1];
         end
         ss1_ff <= speed * speed;

         a2_ff <= a2_in;
         b2_ff <= b2_in;
         c2_ff <= c2_in;

         bll3_ff   <= ab[H-1:0] * ab[H-1:0];
         blh3_ff   <= ab[H-1:0] * ab[2*H-1:H];
         bhh3_ff   <= ab[2*H-1:H] * ab[2*H-1:H];
         all3_ff   <= aa[H-1:0] * ac_c[H-1:0];
         alh3_ff   <= aa[H-1:0] * ac_c[2*H-1:H];
         ahl3_ff   <= aa[2*H-1:H] * ac_c[H-1:0];
         ahh3_ff   <= aa[2*H-1:H] * ac_c[2*H-1:H];
         a3_ff     <= a2_ff;
         b3_ff     <= b2_ff;
         c3_ff     <= c2_ff;
         a_neg3_ff <= a2_ff[ipp_pkg::COEF_W-1];

         bsq4_ff   <= bsq4_in;
         ac4_ff    <= ac4_in;
         a4_ff     <= a3_ff;
         b4_ff     <= b3_ff;
         c4_ff     <= c3_ff;
         a_neg4_ff <= a_neg3_ff;

         d5_ff      <= d5_in;
         num5_ff    <= num5_in;
         den5_ff    <= den5_in;
         a_zero5_ff <= (a4_ff == '0);
         b_zero5_ff <= (b4_ff == '0);
         a_neg5_ff  <= a_neg4_ff;
      end
   end

   assign d_pos = !d5_ff[ipp_pkg::D_W-1] && (d5_ff != '0);

   always_comb begin
      side.cur     = cur_ff[ipp_pkg::FRONT_N-1];
      side.vel     = vel_ff[ipp_pkg::FRONT_N-1];
      side.num_pre = num5_ff;
      side.den     = den5_ff;
      side.a_neg   = a_neg5_ff;
      if (a_zero5_ff) begin
         side.kase = b_zero5_ff ? ipp_pkg::CASE_DEGEN : ipp_pkg::CASE_LINEAR;
      end else begin
         side.kase = d_pos ? ipp_pkg::CASE_QUAD : ipp_pkg::CASE_NOROOT;
      end
   end

   assign disc = d5_ff;

endmodule

`default_nettype wire

@@ rtl/ipp_axis.sv @@
// ----------------------------------------------------------------------------
// Axis displacement unit
// Scales one velocity component by the flight time as a quotient, through a
// split multiplier and a chain of divider cells, then caps and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module ipp_axis (
   input  logic              clock,
   input  logic              en,
   input  ipp_pkg::pos_type  cur,
   input  ipp_pkg::vel_type  vel,
   input  ipp_pkg::num_type  num,
   input  ipp_pkg::coef_type den,
   input  logic              move,
   output ipp_pkg::pos_type  aim
);

   typedef struct packed {
      ipp_pkg::pos_type cur;
      logic             neg;
      logic             big;
      logic             move;
   } axside_type;

   logic [ipp_pkg::AVEL_W-1:0] avel0_ff;
   logic [ipp_pkg::NUM_W-1:0]  anum0_ff;
   logic [ipp_pkg::DREM_W-1:0] aden_ff [4];
   axside_type                 xs_ff [4];
   logic [ipp_pkg::NPP_W-1:0]  pl1_ff, ph1_ff;
   logic [ipp_pkg::PROD_W-1:0] p2_ff;
   logic [ipp_pkg::DREM_W-1:0] rem3_ff;
   logic [ipp_pkg::Q_W-1:0]    dvd3_ff;
   axside_type                 ds_ff [ipp_pkg::DIV_N];

   logic [ipp_pkg::DREM_W-1:0] c_rem [ipp_pkg::DIV_N];
   logic [ipp_pkg::Q_W-1:0]    c_dvd [ipp_pkg::DIV_N];
   logic [ipp_pkg::Q_W-1:0]    c_quo [ipp_pkg::DIV_N];
   logic [ipp_pkg::DREM_W-1:0] c_den [ipp_pkg::DIV_N];

   axside_type                 xs0_in, fin;
   logic signed [ipp_pkg::AIM_W-1:0] mag, sum;
   ipp_pkg::pos_type           sat;

   always_comb begin
      xs0_in.cur  = cur;
      xs0_in.neg  = vel[ipp_pkg::VEL_W-1] ^ num[ipp_pkg::NUM_W-1] ^ den[ipp_pkg::COEF_W-1];
      xs0_in.big  = 1'b0;
      xs0_in.move = move;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         avel0_ff   <= vel[ipp_pkg::VEL_W-1] ? ipp_pkg::AVEL_W'(-vel) : ipp_pkg::AVEL_W'(vel);
         anum0_ff   <= num[ipp_pkg::NUM_W-1] ? ipp_pkg::NUM_W'(-num) : ipp_pkg::NUM_W'(num);
         aden_ff[0] <= den[ipp_pkg::COEF_W-1] ? ipp_pkg::DREM_W'(-den) : ipp_pkg::DREM_W'(den);
         xs_ff[0]   <= xs0_in;

         pl1_ff <= avel0_ff * anum0_ff[ipp_pkg::NHALF_W-1:0];
         ph1_ff <= avel0_ff * anum0_ff[ipp_pkg::NUM_W-1:ipp_pkg::NHALF_W];

         p2_ff <= ipp_pkg::PROD_W'(pl1_ff) + (ipp_pkg::PROD_W'(ph1_ff) << ipp_pkg::NHALF_W);

         for (int k = 1; k < 4; k++) begin
            aden_ff[k] <= aden_ff[k-1];
         end
         for (int k = 1; k < 3; k++) begin
            xs_ff[k] <= xs_ff[k-1];
         end
         xs_ff[3].cur  <= xs_ff[2].cur;
         xs_ff[3].neg  <= xs_ff[2].neg;
         xs_ff[3].move <= xs_ff[2].move;
         xs_ff[3].big  <= p2_ff[ipp_pkg::PROD_W-1:ipp_pkg::Q_W]
                          >= (ipp_pkg::PROD_W-ipp_pkg::Q_W)'(aden_ff[2]);
         rem3_ff <= p2_ff[ipp_pkg::Q_W+ipp_pkg::DREM_W-1:ipp_pkg::Q_W];
         dvd3_ff <= p2_ff[ipp_pkg::Q_W-1:0];

         ds_ff[0] <= xs_ff[3];
         for (int k = 1; k < ipp_pkg::DIV_N; k++) begin
            ds_ff[k] <= ds_ff[k-1];
         end
      end
   end

   for (genvar k = 0; k < ipp_pkg::DIV_N; k++) begin : g_div
      if (k == 0) begin : g_first
         ipp_div_cell u_cell (
            .clock    (clock),
            .en       (en),
            .prev_rem (rem3_ff),
            .prev_dvd (dvd3_ff),
            .prev_quo ('0),
            .prev_den (aden_ff[3]),
            .rem      (c_rem[k]),
            .dvd      (c_dvd[k]),
            .quo      (c_quo[k]),
            .den      (c_den[k])
         );
      end else begin : g_next
         ipp_div_cell u_cell (
            .clock    (clock),
            .en       (en),
            .prev_rem (c_rem[k-1]),
            .prev_dvd (c_dvd[k-1]),
            .prev_quo (c_quo[k-1]),
            .prev_den (c_den[k-1]),
            .rem      (c_rem[k]),
            .dvd      (c_dvd[k]),
            .quo      (c_quo[k]),
            .den      (c_den[k])
         );
      end
   end

   always_comb begin
      fin = ds_ff[ipp_pkg::DIV_N-1];
      mag = fin.big ? (ipp_pkg::AIM_W'(1) << ipp_pkg::Q_W)
                    : ipp_pkg::AIM_W'(c_quo[ipp_pkg::DIV_N-1]);
      sum = fin.neg ? (ipp_pkg::AIM_W'(fin.cur) - mag) : (ipp_pkg::AIM_W'(fin.cur) + mag);
      if (sum[ipp_pkg::AIM_W-1:ipp_pkg::POS_W-1] == '0
          || sum[ipp_pkg::AIM_W-1:ipp_pkg::POS_W-1] == '1) begin
         sat = sum[ipp_pkg::POS_W-1:0];
      end else if (sum[ipp_pkg::AIM_W-1]) begin
         sat = {1'b1, {(ipp_pkg::POS_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(ipp_pkg::POS_W-1){1'b1}}};
      end
      aim = fin.move ? sat : fin.cur;
   end

endmodule

`default_nettype wire

@@ rtl/intercept_point_predictor_core.sv @@
// ----------------------------------------------------------------------------
// Intercept point predictor core
// Predicts where a projectile meets a linearly moving target by solving the
// intercept quadratic exactly, with square root and division cell chains.
// ----------------------------------------------------------------------------
// Stages: a request transfer loads the first of six coefficient stages; then
// come 68 square root cells, one root select stage, four scaling stages,
// 34 divider cells and the output.
// Throughput: one transfer per cycle each way; a one-entry skid stage takes the
// result that finishes under a stall, and the pipeline holds until it drains.
// Reset: projectile_speed returns to 1.0 and the pipeline empties at once.
`default_nettype none

module intercept_point_predictor_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_target_x,
   input  logic signed [31:0]   req_target_y,
   input  logic signed [31:0]   req_target_z,
   input  logic signed [31:0]   req_prev_x,
   input  logic signed [31:0]   req_prev_y,
   input  logic signed [31:0]   req_prev_z,
   input  logic signed [31:0]   req_shooter_x,
   input  logic signed [31:0]   req_shooter_y,
   input  logic signed [31:0]   req_shooter_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_aim_x,
   output logic signed [31:0]   rsp_aim_y,
   output logic signed [31:0]   rsp_aim_z,
   output logic [1:0]           rsp_solve_case,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   localparam int SELIDX = ipp_pkg::FRONT_N + ipp_pkg::SQRT_N;

   logic [ipp_pkg::SPD_W-1:0] speed_ff;
   logic [ipp_pkg::PIPE_N-1:0] valid_ff;
   logic                      en, take, last_valid;

   ipp_pkg::pos_type [ipp_pkg::AXES-1:0] tgt, prv, sht, last_aim;
   ipp_pkg::pos_type [ipp_pkg::AXES-1:0] rsp_aim_ff, skid_aim_ff;
   ipp_pkg::case_type                    rsp_case_ff, skid_case_ff;
   logic                                 rsp_valid_ff, skid_valid_ff;

   logic [ipp_pkg::D_W-1:0]   disc;
   ipp_pkg::side_type         front_side;
   ipp_pkg::side_type         side_ff [ipp_pkg::SQRT_N];
   logic [ipp_pkg::D_W-1:0]   s_rad  [ipp_pkg::SQRT_N];
   logic [ipp_pkg::REM_W-1:0] s_rem  [ipp_pkg::SQRT_N];
   logic [ipp_pkg::E_W-1:0]   s_root [ipp_pkg::SQRT_N];

   ipp_pkg::side_type side_l;
   ipp_pkg::num_type  se, small_r, large_r, num_in;
   logic              move_in;
   ipp_pkg::num_type  num_ff;
   ipp_pkg::coef_type den_ff;
   logic              move_ff;
   ipp_pkg::pos_type [ipp_pkg::AXES-1:0] cur_ff;
   ipp_pkg::vel_type [ipp_pkg::AXES-1:0] vel_ff;
   ipp_pkg::case_type kase_ff [ipp_pkg::AXIS_N + 1];

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {1'b0, speed_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= ipp_pkg::SPD_W'(65536);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == 1'b0) begin
         speed_ff <= csr_pwdata[ipp_pkg::SPD_W-1:0];
      end
   end

   assign en         = !skid_valid_ff;
   assign req_stall  = skid_valid_ff;
   assign take       = rsp_valid_ff && !rsp_stall;
   assign last_valid = valid_ff[ipp_pkg::PIPE_N-1];

   assign tgt = {req_target_z, req_target_y, req_target_x};
   assign prv = {req_prev_z, req_prev_y, req_prev_x};
   assign sht = {req_shooter_z, req_shooter_y, req_shooter_x};

   ipp_front u_front (
      .clock   (clock),
      .en      (en),
      .target  (tgt),
      .prev    (prv),
      .shooter (sht),
      .speed   (speed_ff),
      .disc    (disc),
      .side    (front_side)
   );

   for (genvar k = 0; k < ipp_pkg::SQRT_N; k++) begin : g_sqrt
      if (k == 0) begin : g_first
         ipp_sqrt_cell u_cell (
            .clock     (clock),
            .en        (en),
            .prev_rad  (disc),
            .prev_rem  ('0),
            .prev_root ('0),
            .rad       (s_rad[k]),
            .rem       (s_rem[k]),
            .root      (s_root[k])
         );
      end else begin : g_next
         ipp_sqrt_cell u_cell (
            .clock     (clock),
            .en        (en),
            .prev_rad  (s_rad[k-1]),
            .prev_rem  (s_rem[k-1]),
            .prev_root (s_root[k-1]),
            .rad       (s_rad[k]),
            .rem       (s_rem[k]),
            .root      (s_root[k])
         );
      end
   end

   always_comb begin
      side_l  = side_ff[ipp_pkg::SQRT_N-1];
      se      = side_l.a_neg ? -ipp_pkg::num_type'(s_root[ipp_pkg::SQRT_N-1])
                             : ipp_pkg::num_type'(s_root[ipp_pkg::SQRT_N-1]);
      small_r = side_l.num_pre - se;
      large_r = side_l.num_pre + se;
      num_in  = '0;
      move_in = 1'b0;
      case (side_l.kase)
         ipp_pkg::CASE_LINEAR: begin
            num_in  = side_l.num_pre;
            move_in = 1'b1;
         end
         ipp_pkg::CASE_QUAD: begin
            if (small_r == '0 || small_r[ipp_pkg::NUM_W-1] == side_l.a_neg) begin
               num_in  = small_r;
               move_in = 1'b1;
            end else if (large_r == '0 || large_r[ipp_pkg::NUM_W-1] == side_l.a_neg) begin
               num_in  = large_r;
               move_in = 1'b1;
            end
         end
         default: begin
            move_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= front_side;
         for (int k = 1; k < ipp_pkg::SQRT_N; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         num_ff     <= num_in;
         den_ff     <= side_l.den;
         move_ff    <= move_in;
         cur_ff     <= side_l.cur;
         vel_ff     <= side_l.vel;
         kase_ff[0] <= side_l.kase;
         for (int k = 1; k <= ipp_pkg::AXIS_N; k++) begin
            kase_ff[k] <= kase_ff[k-1];
         end
      end
   end

   for (genvar a = 0; a < ipp_pkg::AXES; a++) begin : g_axis
      ipp_axis u_axis (
         .clock (clock),
         .en    (en),
         .cur   (cur_ff[a]),
         .vel   (vel_ff[a]),
         .num   (num_ff),
         .den   (den_ff),
         .move  (move_ff),
         .aim   (last_aim[a])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            valid_ff <= {valid_ff[ipp_pkg::PIPE_N-2:0], req_valid};
         end
         if (skid_valid_ff) begin
            if (take) begin
               rsp_aim_ff    <= skid_aim_ff;
               rsp_case_ff   <= skid_case_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (last_valid) begin
            if (!rsp_valid_ff || take) begin
               rsp_aim_ff   <= last_aim;
               rsp_case_ff  <= kase_ff[ipp_pkg::AXIS_N];
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_aim_ff   <= last_aim;
               skid_case_ff  <= kase_ff[ipp_pkg::AXIS_N];
               skid_valid_ff <= 1'b1;
            end
         end else if (take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_aim_x      = rsp_aim_ff[0];
   assign rsp_aim_y      = rsp_aim_ff[1];
   assign rsp_aim_z      = rsp_aim_ff[2];
   assign rsp_solve_case = rsp_case_ff;

   // The skid entry is only ever filled behind a waiting result.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a pending result");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && !skid_valid_ff && last_valid) |=> skid_valid_ff)
      else $error("finished result dropped while output was stalled");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipeline moved while frozen");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !take) |=> (skid_valid_ff && $stable(skid_case_ff)))
      else $error("skid entry changed before transfer");

endmodule

`default_nettype wire
